// ----- hdl/tpc_pkg.sv -----
// -----------------------------------------------------------------------------
// tpc_pkg: shared types, constants and helpers for the triangle plane cull
// Holds the item structs, the register map and the Q.30 to Q16.16 rescale.
// -----------------------------------------------------------------------------
package tpc_pkg;

	localparam int CAPACITY   = 256;
	localparam int ADDR_W     = 5;
	localparam int DATA_W     = 32;
	localparam int ROUND_BIAS = 8192;
	localparam int FRAC_SHIFT = 14;

	typedef enum logic [2:0] {
		REG_CENTRE_X = 3'd0,
		REG_CENTRE_Y = 3'd1,
		REG_CENTRE_Z = 3'd2,
		REG_REACH    = 3'd3,
		REG_TOTAL    = 3'd4
	} tpc_reg_t;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
	} tpc_vec_t;

	typedef struct packed {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [15:0] z;
	} tpc_nrm_t;

	typedef struct packed {
		tpc_vec_t a;
		tpc_vec_t b;
		tpc_vec_t c;
		tpc_nrm_t n;
	} tpc_tri_t;

	typedef struct packed {
		logic        accepted;
		logic [7:0]  slot;
		tpc_vec_t    e0;
		tpc_vec_t    e1;
		tpc_vec_t    e2;
		logic        query_done;
	} tpc_res_t;

	// Register contents plus a strobe that restarts the query counters.
	typedef struct packed {
		tpc_vec_t    centre;
		logic [30:0] reach;
		logic [15:0] total;
		logic        restart;
	} tpc_cfg_t;

	// Round a Q.30 value to Q16.16 (ties toward plus infinity) and saturate.
	function automatic logic signed [31:0] to_q16(input logic signed [49:0] x);
		logic signed [50:0] r;
		logic signed [36:0] q;
		r = 51'(x) + 51'(ROUND_BIAS);
		q = 37'(r >>> FRAC_SHIFT);
		if (q[36] && !(&q[35:31])) begin
			return {1'b1, 31'd0};
		end else if (!q[36] && (|q[35:31])) begin
			return {1'b0, {31{1'b1}}};
		end
		return q[31:0];
	endfunction

endpackage

// ----- hdl/tpc_if.sv -----
// -----------------------------------------------------------------------------
// tpc_if: triangle and result channels
// Valid/ready channels carrying one triangle item and one result item.
// -----------------------------------------------------------------------------
interface tpc_tri_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] a_x;
	logic signed [31:0] a_y;
	logic signed [31:0] a_z;
	logic signed [31:0] b_x;
	logic signed [31:0] b_y;
	logic signed [31:0] b_z;
	logic signed [31:0] c_x;
	logic signed [31:0] c_y;
	logic signed [31:0] c_z;
	logic signed [15:0] face_nx;
	logic signed [15:0] face_ny;
	logic signed [15:0] face_nz;

	modport source (output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
		face_nx, face_ny, face_nz, input ready);
	modport sink (input valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
		face_nx, face_ny, face_nz, output ready);
endinterface

interface tpc_res_if;
	logic               valid;
	logic               ready;
	logic               accepted;
	logic [7:0]         slot;
	logic signed [31:0] edge0_x;
	logic signed [31:0] edge0_y;
	logic signed [31:0] edge0_z;
	logic signed [31:0] edge1_x;
	logic signed [31:0] edge1_y;
	logic signed [31:0] edge1_z;
	logic signed [31:0] edge2_x;
	logic signed [31:0] edge2_y;
	logic signed [31:0] edge2_z;
	logic               query_done;

	modport source (output valid, accepted, slot, edge0_x, edge0_y, edge0_z,
		edge1_x, edge1_y, edge1_z, edge2_x, edge2_y, edge2_z, query_done,
		input ready);
	modport sink (input valid, accepted, slot, edge0_x, edge0_y, edge0_z,
		edge1_x, edge1_y, edge1_z, edge2_x, edge2_y, edge2_z, query_done,
		output ready);
endinterface

// ----- hdl/triangle_plane_cull_edge_normals_top.sv -----
// -----------------------------------------------------------------------------
// triangle_plane_cull_edge_normals_top: triangle plane cull with edge normals
// Culls triangles by plane distance, hands out batch slots and returns the
// half-plane normal of each edge of each accepted triangle.
// -----------------------------------------------------------------------------
//  channel   direction  handshake          contents
//  tri_in    in         valid/ready        corners a, b, c (Q16.16), normal (Q2.14)
//  res_out   out        valid/ready        accepted, slot, edge normals, query_done
//  apb       in         psel/penable/pwrite  centre, reach, triangle total
//
// One item per cycle sustained while res_out ready is high; each triangle goes
// into the input register, then the result register, and leaves when ready is high.
// The stage between the input register and the result register holds the
// distance products and three cross products (nine terms), all in parallel.
// Reset clears the valid bits, query counters and config registers, but sets the total to 1.
// A stalled result holds; the input register still fills behind it.
module triangle_plane_cull_edge_normals_top #(
	parameter int CAPACITY = tpc_pkg::CAPACITY
) (
	input  logic                        clk,
	input  logic                        arst_n,
	tpc_tri_if.sink                     tri_in,
	tpc_res_if.source                   res_out,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [tpc_pkg::ADDR_W-1:0]  paddr,
	input  logic [tpc_pkg::DATA_W-1:0]  pwdata,
	output logic [tpc_pkg::DATA_W-1:0]  prdata,
	output logic                        pready
);

	localparam int CntW = $clog2(CAPACITY + 1);

	tpc_pkg::tpc_cfg_t  cfg;
	tpc_pkg::tpc_tri_t  tri_d;
	tpc_pkg::tpc_tri_t  tri_s1;
	tpc_pkg::tpc_res_t  res_d;
	tpc_pkg::tpc_res_t  res_s2;
	tpc_pkg::tpc_vec_t  e0, e1, e2;
	logic               valid_s1;
	logic               valid_s2;
	logic               advance;
	logic               in_take;
	logic               in_reach;
	logic               take;
	logic               done;
	logic [CntW-1:0]    acc_cnt_q;
	logic [15:0]        seen_cnt_q;
	logic [15:0]        seen_nx;

	tpc_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign tri_d.a.x = tri_in.a_x;
	assign tri_d.a.y = tri_in.a_y;
	assign tri_d.a.z = tri_in.a_z;
	assign tri_d.b.x = tri_in.b_x;
	assign tri_d.b.y = tri_in.b_y;
	assign tri_d.b.z = tri_in.b_z;
	assign tri_d.c.x = tri_in.c_x;
	assign tri_d.c.y = tri_in.c_y;
	assign tri_d.c.z = tri_in.c_z;
	assign tri_d.n.x = tri_in.face_nx;
	assign tri_d.n.y = tri_in.face_ny;
	assign tri_d.n.z = tri_in.face_nz;

	assign advance       = !valid_s2 || res_out.ready;
	assign tri_in.ready  = !valid_s1 || advance;
	assign in_take       = tri_in.valid && tri_in.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			tri_s1 <= tri_d;
		end
	end

	tpc_plane_dist u_dist (
		.centre   (cfg.centre),
		.reach    (cfg.reach),
		.corner   (tri_s1.c),
		.nrm      (tri_s1.n),
		.in_reach (in_reach)
	);

	tpc_edge_cross u_edge0 (.p(tri_s1.a), .q(tri_s1.b), .nrm(tri_s1.n), .edge_n(e0));
	tpc_edge_cross u_edge1 (.p(tri_s1.b), .q(tri_s1.c), .nrm(tri_s1.n), .edge_n(e1));
	tpc_edge_cross u_edge2 (.p(tri_s1.c), .q(tri_s1.a), .nrm(tri_s1.n), .edge_n(e2));

	assign take    = in_reach && (acc_cnt_q < CntW'(CAPACITY));
	assign seen_nx = seen_cnt_q + 16'd1;
	// A wrapped count or a zero total also ends the query.
	assign done    = (seen_nx == 16'd0) || (seen_nx >= cfg.total);

	always_comb begin
		res_d.accepted   = take;
		res_d.slot       = take ? 8'(acc_cnt_q) : 8'd0;
		res_d.e0         = take ? e0 : '0;
		res_d.e1         = take ? e1 : '0;
		res_d.e2         = take ? e2 : '0;
		res_d.query_done = done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_cnt_q  <= '0;
			seen_cnt_q <= '0;
		end else if (cfg.restart) begin
			acc_cnt_q  <= '0;
			seen_cnt_q <= '0;
		end else if (valid_s1 && advance) begin
			if (done) begin
				acc_cnt_q  <= '0;
				seen_cnt_q <= '0;
			end else begin
				seen_cnt_q <= seen_nx;
				if (take) begin
					acc_cnt_q <= acc_cnt_q + CntW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			res_s2 <= res_d;
		end
	end

	assign res_out.valid      = valid_s2;
	assign res_out.accepted   = res_s2.accepted;
	assign res_out.slot       = res_s2.slot;
	assign res_out.edge0_x    = res_s2.e0.x;
	assign res_out.edge0_y    = res_s2.e0.y;
	assign res_out.edge0_z    = res_s2.e0.z;
	assign res_out.edge1_x    = res_s2.e1.x;
	assign res_out.edge1_y    = res_s2.e1.y;
	assign res_out.edge1_z    = res_s2.e1.z;
	assign res_out.edge2_x    = res_s2.e2.x;
	assign res_out.edge2_y    = res_s2.e2.y;
	assign res_out.edge2_z    = res_s2.e2.z;
	assign res_out.query_done = res_s2.query_done;

endmodule

// ----- hdl/tpc_apb_regs.sv -----
// -----------------------------------------------------------------------------
// tpc_apb_regs: configuration registers
// APB-style register file for centre, reach and triangle total.
// -----------------------------------------------------------------------------
module tpc_apb_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [tpc_pkg::ADDR_W-1:0]   paddr,
	input  logic [tpc_pkg::DATA_W-1:0]   pwdata,
	output logic [tpc_pkg::DATA_W-1:0]   prdata,
	output logic                         pready,
	output tpc_pkg::tpc_cfg_t            cfg
);

	logic signed [31:0] centre_x_q;
	logic signed [31:0] centre_y_q;
	logic signed [31:0] centre_z_q;
	logic [30:0]        reach_q;
	logic [15:0]        total_q;
	logic               wr_en;
	logic               hit;
	logic [2:0]         idx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign idx    = paddr[4:2];

	always_comb begin
		case (idx)
			tpc_pkg::REG_CENTRE_X, tpc_pkg::REG_CENTRE_Y, tpc_pkg::REG_CENTRE_Z,
			tpc_pkg::REG_REACH, tpc_pkg::REG_TOTAL: hit = 1'b1;
			default: hit = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			centre_x_q <= '0;
			centre_y_q <= '0;
			centre_z_q <= '0;
			reach_q    <= '0;
			total_q    <= 16'd1;
		end else if (wr_en) begin
			case (idx)
				tpc_pkg::REG_CENTRE_X: centre_x_q <= pwdata;
				tpc_pkg::REG_CENTRE_Y: centre_y_q <= pwdata;
				tpc_pkg::REG_CENTRE_Z: centre_z_q <= pwdata;
				tpc_pkg::REG_REACH:    reach_q    <= pwdata[30:0];
				tpc_pkg::REG_TOTAL:    total_q    <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			tpc_pkg::REG_CENTRE_X: prdata = centre_x_q;
			tpc_pkg::REG_CENTRE_Y: prdata = centre_y_q;
			tpc_pkg::REG_CENTRE_Z: prdata = centre_z_q;
			tpc_pkg::REG_REACH:    prdata = {1'b0, reach_q};
			tpc_pkg::REG_TOTAL:    prdata = {16'd0, total_q};
			default:               prdata = '0;
		endcase
	end

	assign cfg.centre.x = centre_x_q;
	assign cfg.centre.y = centre_y_q;
	assign cfg.centre.z = centre_z_q;
	assign cfg.reach    = reach_q;
	assign cfg.total    = total_q;
	// Any write to a defined register starts a new query.
	assign cfg.restart  = wr_en && hit;

endmodule

// ----- hdl/tpc_plane_dist.sv -----
// -----------------------------------------------------------------------------
// tpc_plane_dist: plane distance test
// Exact |(centre - c) . N| in Q.30 compared against reach scaled to Q.30.
// -----------------------------------------------------------------------------
module tpc_plane_dist (
	input  tpc_pkg::tpc_vec_t  centre,
	input  logic [30:0]        reach,
	input  tpc_pkg::tpc_vec_t  corner,
	input  tpc_pkg::tpc_nrm_t  nrm,
	output logic               in_reach
);

	logic signed [31:0] cx, cy, cz, vx, vy, vz;
	logic signed [15:0] nx, ny, nz;
	logic signed [32:0] dx, dy, dz;
	logic signed [48:0] px, py, pz;
	logic signed [50:0] plane_d;
	logic [50:0]        dist_mag;
	logic [44:0]        limit;

	assign cx = centre.x;
	assign cy = centre.y;
	assign cz = centre.z;
	assign vx = corner.x;
	assign vy = corner.y;
	assign vz = corner.z;
	assign nx = nrm.x;
	assign ny = nrm.y;
	assign nz = nrm.z;

	assign dx = 33'(cx) - 33'(vx);
	assign dy = 33'(cy) - 33'(vy);
	assign dz = 33'(cz) - 33'(vz);

	assign px = 49'(dx) * 49'(nx);
	assign py = 49'(dy) * 49'(ny);
	assign pz = 49'(dz) * 49'(nz);

	assign plane_d  = 51'(px) + 51'(py) + 51'(pz);
	assign dist_mag = plane_d[50] ? 51'(-plane_d) : 51'(plane_d);
	assign limit    = {reach, 14'd0};
	assign in_reach = (dist_mag <= 51'(limit));

endmodule

// ----- hdl/tpc_edge_cross.sv -----
// -----------------------------------------------------------------------------
// tpc_edge_cross: edge half-plane normal
// N x (q - p) in Q.30, rescaled to Q16.16 with saturation.
// -----------------------------------------------------------------------------
module tpc_edge_cross (
	input  tpc_pkg::tpc_vec_t  p,
	input  tpc_pkg::tpc_vec_t  q,
	input  tpc_pkg::tpc_nrm_t  nrm,
	output tpc_pkg::tpc_vec_t  edge_n
);

	logic signed [31:0] px, py, pz, qx, qy, qz;
	logic signed [15:0] nx, ny, nz;
	logic signed [32:0] ex, ey, ez;
	logic signed [48:0] m_yz, m_zy, m_zx, m_xz, m_xy, m_yx;
	logic signed [49:0] sx, sy, sz;

	assign px = p.x;
	assign py = p.y;
	assign pz = p.z;
	assign qx = q.x;
	assign qy = q.y;
	assign qz = q.z;
	assign nx = nrm.x;
	assign ny = nrm.y;
	assign nz = nrm.z;

	assign ex = 33'(qx) - 33'(px);
	assign ey = 33'(qy) - 33'(py);
	assign ez = 33'(qz) - 33'(pz);

	assign m_yz = 49'(ny) * 49'(ez);
	assign m_zy = 49'(nz) * 49'(ey);
	assign m_zx = 49'(nz) * 49'(ex);
	assign m_xz = 49'(nx) * 49'(ez);
	assign m_xy = 49'(nx) * 49'(ey);
	assign m_yx = 49'(ny) * 49'(ex);

	assign sx = 50'(m_yz) - 50'(m_zy);
	assign sy = 50'(m_zx) - 50'(m_xz);
	assign sz = 50'(m_xy) - 50'(m_yx);

	assign edge_n.x = tpc_pkg::to_q16(sx);
	assign edge_n.y = tpc_pkg::to_q16(sy);
	assign edge_n.z = tpc_pkg::to_q16(sz);

endmodule

// ----- hdl/tpc_checker.sv -----
// -----------------------------------------------------------------------------
// tpc_checker: port-level checks for the triangle plane cull
// Watches the channels of the top level and is bound to it.
// -----------------------------------------------------------------------------
module tpc_checker #(
	parameter int CAPACITY = tpc_pkg::CAPACITY
) (
	input logic               clk,
	input logic               arst_n,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic               accepted,
	input logic [7:0]         slot,
	input logic signed [31:0] edge0_x,
	input logic signed [31:0] edge1_y,
	input logic signed [31:0] edge2_z
);

	// A waiting result keeps its contents.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(slot) && $stable(edge0_x)
			&& $stable(accepted))
		else $error("result changed while stalled");

	// A culled triangle carries no slot and no edge normals.
	a_culled_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !accepted |-> slot == 8'd0 && edge0_x == '0 && edge1_y == '0
			&& edge2_z == '0)
		else $error("culled item carries data");

	// Slots never reach the batch capacity.
	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && accepted |-> 32'(slot) < CAPACITY)
		else $error("slot beyond capacity");

	// The input only stalls behind a result that is held back.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without a waiting result");

endmodule

bind triangle_plane_cull_edge_normals_top tpc_checker #(.CAPACITY(CAPACITY)) u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (tri_in.ready),
	.out_valid (res_out.valid),
	.out_ready (res_out.ready),
	.accepted  (res_out.accepted),
	.slot      (res_out.slot),
	.edge0_x   (res_out.edge0_x),
	.edge1_y   (res_out.edge1_y),
	.edge2_z   (res_out.edge2_z)
);
